// ===== design/epa_pkg.sv =====
// Shared types, widths and the arctangent table for the ellipse point block.
`timescale 1ns / 1ps

package epa_pkg;

  localparam int CordicStages = 16;
  localparam int SqrtStages   = 32;
  localparam int DivStages    = 31;
  localparam int NormSteps    = 6;

  localparam int AW  = 23;   // semi-axis
  localparam int CW  = 24;   // coordinate
  localparam int XW  = 32;   // CORDIC x/y
  localparam int ZW  = 34;   // CORDIC angle residual
  localparam int MW  = 29;   // |x|, |y|
  localparam int PW  = 52;   // axis * magnitude
  localparam int NW  = 64;   // normalizer word
  localparam int UW  = 31;   // normalized ratio term
  localparam int SRW = 35;   // sqrt partial remainder
  localparam int HW  = 32;   // sqrt root
  localparam int DRW = 33;   // divider partial remainder
  localparam int QW  = 31;   // quotient
  localparam int SW  = 5;    // CORDIC stage index

  localparam logic signed [XW-1:0] CordicX0 = XW'(268435456);

  typedef enum logic [1:0] {
    RegSemiA   = 2'd0,
    RegSemiB   = 2'd1,
    RegCenterX = 2'd2,
    RegCenterY = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic negx;
    logic negy;
    logic zero;
  } tag_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cord_t;

  typedef struct packed {
    logic [NW-1:0]  rad;
    logic [SRW-1:0] rem;
    logic [HW-1:0]  root;
    logic [UW-1:0]  u;
    logic [UW-1:0]  v;
    tag_t           tag;
  } sqrt_t;

  typedef struct packed {
    logic [HW-1:0]  h;
    logic [DRW-1:0] rp;
    logic [DRW-1:0] rq;
    logic [QW-1:0]  qp;
    logic [QW-1:0]  qq;
    tag_t           tag;
  } div_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turns(input logic [SW-1:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004755;
      5'd4:    r = 30'd42667332;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/epa_channels.sv =====
// Valid/ready channel interfaces for phase beats and point beats.
`timescale 1ns / 1ps

interface epa_in_if;
  logic        valid;
  logic        ready;
  logic [16:0] phase;
  modport source (output valid, output phase, input ready);
  modport sink (input valid, input phase, output ready);
endinterface

interface epa_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

// ===== design/epa_cordic_cell.sv =====
// One CORDIC rotation stage of the angle pipeline.
`timescale 1ns / 1ps

module epa_cordic_cell import epa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [SW-1:0] stage_i,
  input  logic          valid_i,
  input  cord_t         d_i,
  output logic          valid_o,
  output cord_t         d_o
);

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] at;
  cord_t                d_d, d_q;
  logic                 valid_q;

  always_comb begin
    xs  = d_i.x >>> stage_i;
    ys  = d_i.y >>> stage_i;
    at  = signed'(ZW'(atan_turns(stage_i)));
    d_d = d_i;
    if (!d_i.z[ZW-1]) begin
      d_d.x = d_i.x - ys;
      d_d.y = d_i.y + xs;
      d_d.z = d_i.z - at;
    end else begin
      d_d.x = d_i.x + ys;
      d_d.y = d_i.y - xs;
      d_d.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

// ===== design/epa_sqrt_cell.sv =====
// One root bit of the pipelined integer square root.
`timescale 1ns / 1ps

module epa_sqrt_cell import epa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  sqrt_t d_i,
  output logic  valid_o,
  output sqrt_t d_o
);

  logic [SRW-1:0] pre, trial;
  sqrt_t          d_d, d_q;
  logic           valid_q;

  always_comb begin
    pre   = {d_i.rem[SRW-3:0], d_i.rad[NW-1:NW-2]};
    trial = {1'b0, d_i.root, 2'b01};
    d_d   = d_i;
    d_d.rad = {d_i.rad[NW-3:0], 2'b00};
    if (pre >= trial) begin
      d_d.rem  = pre - trial;
      d_d.root = {d_i.root[HW-2:0], 1'b1};
    end else begin
      d_d.rem  = pre;
      d_d.root = {d_i.root[HW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

// ===== design/epa_div_cell.sv =====
// One quotient bit of the two parallel restoring dividers.
`timescale 1ns / 1ps

module epa_div_cell import epa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t d_i,
  output logic valid_o,
  output div_t d_o
);

  logic [DRW-1:0] hx, remp, remq;
  logic           bp, bq;
  div_t           d_d, d_q;
  logic           valid_q;

  always_comb begin
    hx   = {1'b0, d_i.h};
    bp   = d_i.rp >= hx;
    bq   = d_i.rq >= hx;
    remp = bp ? d_i.rp - hx : d_i.rp;
    remq = bq ? d_i.rq - hx : d_i.rq;
    d_d    = d_i;
    d_d.rp = {remp[DRW-2:0], 1'b0};
    d_d.rq = {remq[DRW-2:0], 1'b0};
    d_d.qp = {d_i.qp[QW-2:0], bp};
    d_d.qq = {d_i.qq[QW-2:0], bq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

// ===== design/ellipse_point_at_angle_core.sv =====
// Top level: ellipse point at a polar angle, fully pipelined.
`timescale 1ns / 1ps

// Usage
//   in_ch carries one phase beat (fraction of a turn, phase/65536); out_ch
//   returns one point beat (pos_x, pos_y, signed Q15.8, saturated) per phase,
//   in order. Semi-axes and centre are set over the APB port at byte
//   addresses 0, 4, 8, 12; write them only while the pipeline is empty.
// Pipeline: phase beat to point beat passes the CORDIC row (16 CORDIC stages),
//   magnitude and scale, a six-step normalizer, squares, a 32-cell square root
//   row, a 31-cell divider row, the final scale and the output register.
// Throughput: one beat per cycle while out_ch is not stalled; every stage is
//   one cell of a pipeline.
// Stall: all stages advance together. While a point beat waits unaccepted
//   the whole pipeline holds and in_ch.ready is low; otherwise in_ch.ready
//   is high, also while a finished beat is being taken.
// Reset: clears all valid bits; semi-axes return to 1.0, centre to 0.
module ellipse_point_at_angle_core import epa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  epa_in_if.sink       in_ch,
  epa_out_if.source    out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  // ---------------- configuration
  logic [AW-1:0]        semi_a_q, semi_b_q;
  logic signed [CW-1:0] center_x_q, center_y_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx, rd_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);
  assign rd_idx  = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      semi_a_q   <= AW'(256);
      semi_b_q   <= AW'(256);
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegSemiA:   semi_a_q   <= pwdata[AW-1:0];
        RegSemiB:   semi_b_q   <= pwdata[AW-1:0];
        RegCenterX: center_x_q <= signed'(pwdata[CW-1:0]);
        RegCenterY: center_y_q <= signed'(pwdata[CW-1:0]);
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (rd_idx)
      RegSemiA:   prdata = {9'b0, semi_a_q};
      RegSemiB:   prdata = {9'b0, semi_b_q};
      RegCenterX: prdata = {{8{center_x_q[CW-1]}}, center_x_q};
      RegCenterY: prdata = {{8{center_y_q[CW-1]}}, center_y_q};
      default:    prdata = '0;
    endcase
  end

  // ---------------- flow control
  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- half-turn fold, CORDIC row
  logic [31:0] th, th_f;
  logic        flip;
  cord_t       cord_s [0:CordicStages];
  logic        cord_v [0:CordicStages];

  always_comb begin
    th   = {in_ch.phase[15:0], 16'b0};
    flip = th[31] ^ th[30];
    th_f = flip ? th + 32'h8000_0000 : th;
    cord_s[0].x    = CordicX0;
    cord_s[0].y    = '0;
    cord_s[0].z    = ZW'(signed'(th_f));
    cord_s[0].flip = flip;
  end
  assign cord_v[0] = in_ch.valid;

  for (genvar i = 0; i < CordicStages; i++) begin : g_cordic
    epa_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (SW'(i)),
      .valid_i (cord_v[i]),
      .d_i     (cord_s[i]),
      .valid_o (cord_v[i+1]),
      .d_o     (cord_s[i+1])
    );
  end

  // ---------------- magnitudes and axis scaling
  logic signed [XW-1:0] fx, fy;
  logic [MW-1:0]        mc_q, ms_q;
  tag_t                 tag1_q, tag2_q;
  logic                 v1_q, v2_q;
  logic [PW-1:0]        u_q, v_q;

  always_comb begin
    fx = cord_s[CordicStages].flip ? -cord_s[CordicStages].x : cord_s[CordicStages].x;
    fy = cord_s[CordicStages].flip ? -cord_s[CordicStages].y : cord_s[CordicStages].y;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mc_q        <= fx[XW-1] ? MW'(-fx) : MW'(fx);
      ms_q        <= fy[XW-1] ? MW'(-fy) : MW'(fy);
      tag1_q.negx <= fx[XW-1];
      tag1_q.negy <= fy[XW-1];
      tag1_q.zero <= 1'b0;
      u_q         <= PW'(semi_b_q) * PW'(mc_q);
      v_q         <= PW'(semi_a_q) * PW'(ms_q);
      tag2_q      <= tag1_q;
    end
  end

  // ---------------- normalizer: leading one of u|v to bit 63
  logic [NW-1:0] nu_q [0:NormSteps];
  logic [NW-1:0] nv_q [0:NormSteps];
  tag_t          ntag_q [0:NormSteps];
  logic          nvld_q [0:NormSteps];

  always_ff @(posedge clk_i) begin
    if (en) begin
      nu_q[0]   <= NW'(u_q);
      nv_q[0]   <= NW'(v_q);
      ntag_q[0] <= '{negx: tag2_q.negx, negy: tag2_q.negy, zero: (u_q | v_q) == '0};
    end
  end

  for (genvar k = 0; k < NormSteps; k++) begin : g_norm
    localparam int Sh = 32 >> k;
    logic [NW-1:0] both;
    assign both = nu_q[k] | nv_q[k];
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (both[NW-1 -: Sh] == '0) begin
          nu_q[k+1] <= nu_q[k] << Sh;
          nv_q[k+1] <= nv_q[k] << Sh;
        end else begin
          nu_q[k+1] <= nu_q[k];
          nv_q[k+1] <= nv_q[k];
        end
        ntag_q[k+1] <= ntag_q[k];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nvld_q[k+1] <= 1'b0;
      end else if (en) begin
        nvld_q[k+1] <= nvld_q[k];
      end
    end
  end

  // ---------------- squares and sum
  logic [UW-1:0]   un, vn, squ_u_q, squ_v_q;
  logic [2*UW-1:0] usq_q, vsq_q;
  tag_t            sqtag_q;
  logic            sqv_q;
  sqrt_t           sq_s [0:SqrtStages];
  logic            sq_v [0:SqrtStages];

  assign un = nu_q[NormSteps][NW-1 -: UW];
  assign vn = nv_q[NormSteps][NW-1 -: UW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      usq_q   <= un * un;
      vsq_q   <= vn * vn;
      squ_u_q <= un;
      squ_v_q <= vn;
      sqtag_q <= ntag_q[NormSteps];
      sq_s[0].rad  <= NW'(usq_q) + NW'(vsq_q);
      sq_s[0].rem  <= '0;
      sq_s[0].root <= '0;
      sq_s[0].u    <= squ_u_q;
      sq_s[0].v    <= squ_v_q;
      sq_s[0].tag  <= sqtag_q;
    end
  end

  for (genvar j = 0; j < SqrtStages; j++) begin : g_sqrt
    epa_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[j]),
      .d_i     (sq_s[j]),
      .valid_o (sq_v[j+1]),
      .d_o     (sq_s[j+1])
    );
  end

  // ---------------- dividers p = u*2^30/h, q = v*2^30/h
  div_t dv_s [0:DivStages];
  logic dv_v [0:DivStages];

  always_comb begin
    dv_s[0].h   = sq_s[SqrtStages].root;
    dv_s[0].rp  = DRW'(sq_s[SqrtStages].u);
    dv_s[0].rq  = DRW'(sq_s[SqrtStages].v);
    dv_s[0].qp  = '0;
    dv_s[0].qq  = '0;
    dv_s[0].tag = sq_s[SqrtStages].tag;
  end
  assign dv_v[0] = sq_v[SqrtStages];

  for (genvar m = 0; m < DivStages; m++) begin : g_div
    epa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[m]),
      .d_i     (dv_s[m]),
      .valid_o (dv_v[m+1]),
      .d_o     (dv_s[m+1])
    );
  end

  // ---------------- final scale, sign, centre, saturate
  localparam int XPW = AW + QW;
  logic [XPW-1:0]       px_q, py_q;
  tag_t                 mtag_q;
  logic                 mv_q;
  logic [XPW:0]         rx, ry;
  logic signed [CW+1:0] dx, dy, sx, sy;
  logic signed [CW-1:0] pos_x_q, pos_y_q;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] s);
    logic signed [CW-1:0] r;
    if (s > (CW+2)'(8388607)) begin
      r = CW'(8388607);
    end else if (s < -(CW+2)'(8388608)) begin
      r = CW'(-8388608);
    end else begin
      r = s[CW-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= XPW'(semi_a_q) * XPW'(dv_s[DivStages].qp);
      py_q   <= XPW'(semi_b_q) * XPW'(dv_s[DivStages].qq);
      mtag_q <= dv_s[DivStages].tag;
    end
  end

  always_comb begin
    rx = (XPW+1)'(px_q) + (XPW+1)'(1 << 29);
    ry = (XPW+1)'(py_q) + (XPW+1)'(1 << 29);
    dx = signed'({1'b0, rx[XPW:30]});
    dy = signed'({1'b0, ry[XPW:30]});
    if (mtag_q.negx) dx = -dx;
    if (mtag_q.negy) dy = -dy;
    if (mtag_q.zero) begin
      dx = '0;
      dy = '0;
    end
    sx = (CW+2)'(center_x_q) + dx;
    sy = (CW+2)'(center_y_q) + dy;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_q <= sat(sx);
      pos_y_q <= sat(sy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      nvld_q[0]   <= 1'b0;
      sqv_q       <= 1'b0;
      sq_v[0]     <= 1'b0;
      mv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= cord_v[CordicStages];
      v2_q        <= v1_q;
      nvld_q[0]   <= v2_q;
      sqv_q       <= nvld_q[NormSteps];
      sq_v[0]     <= sqv_q;
      mv_q        <= dv_v[DivStages];
      out_valid_q <= mv_q;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.pos_x = pos_x_q;
  assign out_ch.pos_y = pos_y_q;

endmodule

// ===== design/epa_checker.sv =====
// Port-level assertions for the ellipse point block, bound to the top level.
`timescale 1ns / 1ps

module epa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [23:0] pos_x_i,
  input logic        pready_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pos_x_i))
    else $error("point beat dropped or changed while stalled");

  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled while output free");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> (!out_valid_i || out_ready_i))
    else $error("input taken while output stalled");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("point beat valid after reset");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("pready low");

endmodule

bind ellipse_point_at_angle_core epa_checker u_epa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .pos_x_i     (out_ch.pos_x),
  .pready_i    (pready)
);

// ===== tb/sv/ellipse_point_at_angle_core_tb.sv =====
// Testbench for the ellipse point block: directed table, random phases, scoreboard checks.
`timescale 1ns / 1ps

module ellipse_point_at_angle_core_tb;
  import epa_pkg::*;

  localparam int NumRandom = 1250;
  localparam int Latency   = CordicStages + 76;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } point_t;

  typedef struct {
    logic [16:0]        phase;
    bit                 known;
    logic signed [23:0] ex;
    logic signed [23:0] ey;
  } vec_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  epa_in_if  in_ch ();
  epa_out_if out_ch ();

  ellipse_point_at_angle_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [22:0]        axis_a, axis_b;
  logic signed [23:0] cen_x, cen_y;
  point_t             pending_points[$];
  int unsigned        errors;
  int unsigned        cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic signed [63:0] fshift(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [23:0] clamp24(logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic point_t ellipse_point(logic [16:0] phase);
    logic [31:0] th;
    bit flip, negx, negy;
    logic signed [63:0] cx, cy, z, xs, ys, dx, dy;
    logic [63:0] mc, ms, u, v, mx, h, p, q;
    logic [63:0] atn [24];
    point_t r;
    atn = '{536870912, 316933406, 167458907, 85004755, 42667332, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    th = {phase[15:0], 16'd0};
    flip = ((th + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) th = th + 32'h8000_0000;
    z = {{32{th[31]}}, th};
    cx = 64'sd1 << 28;
    cy = 0;
    dx = 0;
    dy = 0;
    for (int i = 0; i < CordicStages && i < 24; i++) begin
      xs = fshift(cx, i);
      ys = fshift(cy, i);
      if (z >= 0) begin
        cx = cx - ys; cy = cy + xs; z = z - $signed(atn[i]);
      end else begin
        cx = cx + ys; cy = cy - xs; z = z + $signed(atn[i]);
      end
    end
    if (flip) begin
      cx = -cx; cy = -cy;
    end
    negx = cx < 0;
    negy = cy < 0;
    mc = negx ? -cx : cx;
    ms = negy ? -cy : cy;
    u = axis_b * mc;
    v = axis_a * ms;
    mx = (u > v) ? u : v;
    if (mx != 0) begin
      while (mx >= (64'd1 << 31)) begin
        u = u >> 1; v = v >> 1; mx = mx >> 1;
      end
      while (mx < (64'd1 << 30)) begin
        u = u << 1; v = v << 1; mx = mx << 1;
      end
      h = isqrt(u * u + v * v);
      p = (u << 30) / h;
      q = (v << 30) / h;
      dx = (axis_a * p + (64'd1 << 29)) >> 30;
      dy = (axis_b * q + (64'd1 << 29)) >> 30;
      if (negx) dx = -dx;
      if (negy) dy = -dy;
    end
    r.x = clamp24(cen_x + dx);
    r.y = clamp24(cen_y + dy);
    return r;
  endfunction

  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegSemiA:   axis_a = val[22:0];
      RegSemiB:   axis_b = val[22:0];
      RegCenterX: cen_x = val[23:0];
      RegCenterY: cen_y = val[23:0];
      default: ;
    endcase
  endtask

  // valid stays high into a following beat sent with no gap
  task automatic send_phase(logic [16:0] ph);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.phase <= ph;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_points.push_back(ellipse_point(ph));
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  // sink side: random stall, then compare with the oldest expectation
  initial begin
    int stall;
    point_t exp_pt;
    out_ch.ready = 1'b0;
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d", $time, out_ch.pos_x, out_ch.pos_y);
        errors++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (exp_pt.x !== out_ch.pos_x) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, exp_pt.x, out_ch.pos_x);
          errors++;
        end
        if (exp_pt.y !== out_ch.pos_y) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, exp_pt.y, out_ch.pos_y);
          errors++;
        end
      end
    end
  end

  initial begin
    vec_t tbl[$];
    point_t got;
    logic [16:0] ph;
    errors = 0;
    cycles = 0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.phase = '0;
    axis_a = 23'd256; axis_b = 23'd256; cen_x = '0; cen_y = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset axes: unit circle, known points at quarter turns
    tbl = '{
      '{17'd0,     1'b1, 24'sd256,  24'sd0},
      '{17'd65536, 1'b1, 24'sd256,  24'sd0},
      '{17'd16384, 1'b1, 24'sd0,    24'sd256},
      '{17'd32768, 1'b1, -24'sd256, 24'sd0},
      '{17'd49152, 1'b1, 24'sd0,    -24'sd256},
      '{17'd8192,  1'b0, 0, 0},
      '{17'd16383, 1'b0, 0, 0},
      '{17'd16385, 1'b0, 0, 0},
      '{17'd49151, 1'b0, 0, 0},
      '{17'd65535, 1'b0, 0, 0},
      '{17'd98304, 1'b0, 0, 0},
      '{17'h1FFFF, 1'b0, 0, 0},
      '{17'h15555, 1'b0, 0, 0},
      '{17'h0AAAA, 1'b0, 0, 0}
    };
    foreach (tbl[i]) begin
      got = ellipse_point(tbl[i].phase);
      if (tbl[i].known && (got.x !== tbl[i].ex || got.y !== tbl[i].ey)) begin
        $display("%0t: table row %0d expected %0d,%0d actual %0d,%0d", $time, i,
                 tbl[i].ex, tbl[i].ey, got.x, got.y);
        errors++;
      end
      send_phase(tbl[i].phase);
    end
    drain();

    // zero axes: result equals the centre
    reg_write(RegSemiA, 32'd0);
    reg_write(RegSemiB, 32'd0);
    reg_write(RegCenterX, 32'h0080_0000);
    reg_write(RegCenterY, 32'h007F_FFFF);
    send_phase(17'd0);
    send_phase(17'd12345);
    drain();

    // largest axes and extreme centres: saturation
    reg_write(RegSemiA, 32'h007F_FFFF);
    reg_write(RegSemiB, 32'h007F_FFFF);
    send_phase(17'd0);
    send_phase(17'd16384);
    send_phase(17'd32768);
    send_phase(17'd49152);
    send_phase(17'd5000);
    drain();
    reg_write(RegSemiA, 32'd1);
    reg_write(RegSemiB, 32'h007F_FFFF);
    reg_write(RegCenterX, 32'd0);
    reg_write(RegCenterY, 32'd0);
    send_phase(17'd100);
    send_phase(17'd40000);
    drain();

    for (int k = 0; k < NumRandom; k++) begin
      if (k % 250 == 0) begin
        drain();
        reg_write(RegSemiA, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65535));
        reg_write(RegSemiB, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65535));
        reg_write(RegCenterX, $urandom);
        reg_write(RegCenterY, $urandom);
      end
      ph = 17'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        ph = {1'($urandom_range(0, 1)), 2'($urandom), 14'd0};
      end
      send_phase(ph);
    end
    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
